// ===== rtl/srbp_pkg.sv =====
// Package for the sync record batch parser: payload structs, phase and
// result codes, sizing constants and small helper functions.
// Depends on nothing; every rtl file refers to it by scoped names.
package srbp_pkg;

    // Field length limits of the record format.
    localparam int TEXT_FIELD_CAP = 32;
    localparam int PAYLOAD_CAP    = 256;

    // Most results one input byte can cause, and the result queue depth.
    localparam int MAX_RES   = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    // Configuration register map.
    localparam int           APB_ADDR_W     = 2;
    localparam logic [1:0]   ADDR_MAX_REC   = 2'd0;
    localparam logic [7:0]   MAX_REC_RESET  = 8'd255;

    // Result kinds.
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_RECORD  = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    // Field selectors.
    localparam logic [2:0] FSEL_SRC = 3'd0;
    localparam logic [2:0] FSEL_DST = 3'd1;
    localparam logic [2:0] FSEL_TYP = 3'd2;
    localparam logic [2:0] FSEL_PRI = 3'd3;
    localparam logic [2:0] FSEL_PAY = 3'd4;

    // Verdict codes; VERD_OK doubles as "no error".
    localparam logic [2:0] VERD_OK     = 3'd0;
    localparam logic [2:0] VERD_EMPTY  = 3'd1;
    localparam logic [2:0] VERD_TRUNC  = 3'd2;
    localparam logic [2:0] VERD_BADLEN = 3'd3;
    localparam logic [2:0] VERD_MANY   = 3'd4;
    localparam logic [2:0] VERD_TRAIL  = 3'd5;

    // Destination match progress: 3 means "ALL" seen so far, 4 means mismatch.
    localparam logic [2:0] DEST_ALL  = 3'd3;
    localparam logic [2:0] DEST_MISS = 3'd4;

    typedef enum logic [3:0] {
        PH_COUNT   = 4'd0,
        PH_ID      = 4'd1,
        PH_LEN_SRC = 4'd2,
        PH_SRC     = 4'd3,
        PH_LEN_DST = 4'd4,
        PH_DST     = 4'd5,
        PH_LEN_TYP = 4'd6,
        PH_TYP     = 4'd7,
        PH_LEN_PRI = 4'd8,
        PH_PRI     = 4'd9,
        PH_HOPS    = 4'd10,
        PH_PLEN    = 4'd11,
        PH_PAY     = 4'd12,
        PH_TAIL    = 4'd13
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       body_end;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  record_index;
        logic [2:0]  field_sel;
        logic [7:0]  byte_pos;
        logic [7:0]  data_byte;
        logic [31:0] record_id;
        logic [7:0]  hop_count;
        logic        is_broadcast;
        logic [2:0]  verdict;
        logic [7:0]  records_total;
        logic        final_flag;
    } t_res;

    // All results caused by one accepted byte, in order from row 0.
    typedef struct packed {
        logic [RES_CNT_W-1:0]     n;
        t_res [MAX_RES-1:0]       rows;
    } t_bundle;

    function automatic t_res mk_data(input logic [7:0] idx, input logic [2:0] fsel,
                                     input logic [7:0] pos, input logic [7:0] b);
        t_res r;
        r              = '0;
        r.kind         = KIND_DATA;
        r.record_index = idx;
        r.field_sel    = fsel;
        r.byte_pos     = pos;
        r.data_byte    = b;
        return r;
    endfunction

    function automatic t_res mk_record(input logic [7:0] idx, input logic [31:0] id,
                                       input logic [7:0] hops, input logic bcast);
        t_res r;
        r              = '0;
        r.kind         = KIND_RECORD;
        r.record_index = idx;
        r.record_id    = id;
        r.hop_count    = hops;
        r.is_broadcast = bcast;
        return r;
    endfunction

    function automatic t_res mk_verdict(input logic [2:0] v, input logic [7:0] total);
        t_res r;
        r               = '0;
        r.kind          = KIND_VERDICT;
        r.verdict       = v;
        r.records_total = total;
        return r;
    endfunction

endpackage

// ===== rtl/srbp_parse.sv =====
// Byte parser of the sync record batch parser: holds the batch state and
// turns one accepted byte into a bundle of up to three results.
// Depends on srbp_pkg.
module srbp_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  srbp_pkg::t_in    i_in,
    input  logic [7:0]       i_rec_limit,
    output srbp_pkg::t_bundle o_bundle
);

    srbp_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_expected, n_expected;
    logic [7:0]  r_done, n_done;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_pos, n_pos;
    logic [31:0] r_id, n_id;
    logic [7:0]  r_hops, n_hops;
    logic [2:0]  r_dest, n_dest;
    logic [2:0]  r_err, n_err;

    logic [7:0]  b;
    logic        do_finish;
    logic        do_start;
    logic [2:0]  verd;
    logic [srbp_pkg::RES_CNT_W-1:0] res_n;
    srbp_pkg::t_res [srbp_pkg::MAX_RES-1:0] rows;

    assign b = i_in.in_byte;

    function automatic logic [2:0] field_of(input srbp_pkg::t_phase ph);
        case (ph)
            srbp_pkg::PH_SRC: return srbp_pkg::FSEL_SRC;
            srbp_pkg::PH_DST: return srbp_pkg::FSEL_DST;
            srbp_pkg::PH_TYP: return srbp_pkg::FSEL_TYP;
            srbp_pkg::PH_PRI: return srbp_pkg::FSEL_PRI;
            default:          return srbp_pkg::FSEL_PAY;
        endcase
    endfunction

    // Characters of the broadcast destination "ALL".
    function automatic logic [7:0] all_char(input logic [1:0] p);
        case (p)
            2'd0:    return 8'h41;
            2'd1:    return 8'h4C;
            2'd2:    return 8'h4C;
            default: return 8'h00;
        endcase
    endfunction

    always_comb begin
        n_phase    = r_phase;
        n_expected = r_expected;
        n_done     = r_done;
        n_left     = r_left;
        n_pos      = r_pos;
        n_id       = r_id;
        n_hops     = r_hops;
        n_dest     = r_dest;
        n_err      = r_err;
        do_finish  = 1'b0;
        do_start   = 1'b0;
        verd       = srbp_pkg::VERD_OK;
        res_n      = '0;
        rows       = '0;

        if (i_take && r_err == srbp_pkg::VERD_OK) begin
            case (r_phase)
                srbp_pkg::PH_COUNT: begin
                    n_expected = b;
                    n_done     = 8'd0;
                    if (b == 8'd0) begin
                        n_err = srbp_pkg::VERD_EMPTY;
                    end else if (b > i_rec_limit) begin
                        n_err = srbp_pkg::VERD_MANY;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                srbp_pkg::PH_ID: begin
                    n_id  = r_id | ({24'd0, b} << {r_pos[1:0], 3'b000});
                    n_pos = r_pos + 8'd1;
                    if (r_pos >= 8'd3) begin
                        n_phase = srbp_pkg::PH_LEN_SRC;
                    end
                end
                srbp_pkg::PH_LEN_SRC, srbp_pkg::PH_LEN_DST,
                srbp_pkg::PH_LEN_TYP, srbp_pkg::PH_LEN_PRI: begin
                    if (b == 8'd0 || int'(b) >= srbp_pkg::TEXT_FIELD_CAP) begin
                        n_err = srbp_pkg::VERD_BADLEN;
                    end else begin
                        n_left  = b;
                        n_pos   = 8'd0;
                        n_phase = srbp_pkg::t_phase'(r_phase + 4'd1);
                    end
                end
                srbp_pkg::PH_SRC, srbp_pkg::PH_DST,
                srbp_pkg::PH_TYP, srbp_pkg::PH_PRI: begin
                    rows[res_n] = srbp_pkg::mk_data(r_done, field_of(r_phase), r_pos, b);
                    res_n       = res_n + srbp_pkg::RES_CNT_W'(1);
                    if (r_phase == srbp_pkg::PH_DST) begin
                        if (r_pos < 8'd3 && {5'd0, r_dest} == r_pos
                            && b == all_char(r_pos[1:0])) begin
                            n_dest = r_pos[2:0] + 3'd1;
                        end else begin
                            n_dest = srbp_pkg::DEST_MISS;
                        end
                    end
                    n_pos  = r_pos + 8'd1;
                    n_left = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_phase = srbp_pkg::t_phase'(r_phase + 4'd1);
                    end
                end
                srbp_pkg::PH_HOPS: begin
                    n_hops  = b;
                    n_phase = srbp_pkg::PH_PLEN;
                end
                srbp_pkg::PH_PLEN: begin
                    if (int'(b) >= srbp_pkg::PAYLOAD_CAP) begin
                        n_err = srbp_pkg::VERD_BADLEN;
                    end else if (b == 8'd0) begin
                        do_finish = 1'b1;
                    end else begin
                        n_left  = b;
                        n_pos   = 8'd0;
                        n_phase = srbp_pkg::PH_PAY;
                    end
                end
                srbp_pkg::PH_PAY: begin
                    rows[res_n] = srbp_pkg::mk_data(r_done, srbp_pkg::FSEL_PAY, r_pos, b);
                    res_n       = res_n + srbp_pkg::RES_CNT_W'(1);
                    n_pos       = r_pos + 8'd1;
                    n_left      = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        do_finish = 1'b1;
                    end
                end
                default: begin
                    n_err = srbp_pkg::VERD_TRAIL;
                end
            endcase

            if (do_finish) begin
                rows[res_n] = srbp_pkg::mk_record(r_done, r_id, r_hops,
                                                  r_dest == srbp_pkg::DEST_ALL);
                res_n       = res_n + srbp_pkg::RES_CNT_W'(1);
                n_done      = r_done + 8'd1;
                if (r_done + 8'd1 == r_expected) begin
                    n_phase = srbp_pkg::PH_TAIL;
                end else begin
                    do_start = 1'b1;
                end
            end

            if (do_start) begin
                n_phase = srbp_pkg::PH_ID;
                n_pos   = 8'd0;
                n_id    = 32'd0;
                n_hops  = 8'd0;
                n_dest  = 3'd0;
            end
        end

        if (i_take && i_in.body_end) begin
            if (n_err != srbp_pkg::VERD_OK) begin
                verd = n_err;
            end else if (n_phase == srbp_pkg::PH_TAIL) begin
                verd = srbp_pkg::VERD_OK;
            end else begin
                verd = srbp_pkg::VERD_TRUNC;
            end
            rows[res_n] = srbp_pkg::mk_verdict(verd,
                              (verd == srbp_pkg::VERD_OK) ? n_done : 8'd0);
            res_n       = res_n + srbp_pkg::RES_CNT_W'(1);
            // The batch is over; start clean for the next one.
            n_phase    = srbp_pkg::PH_COUNT;
            n_expected = 8'd0;
            n_done     = 8'd0;
            n_left     = 8'd0;
            n_pos      = 8'd0;
            n_id       = 32'd0;
            n_hops     = 8'd0;
            n_dest     = 3'd0;
            n_err      = srbp_pkg::VERD_OK;
        end

        for (int k = 0; k < srbp_pkg::MAX_RES; k++) begin
            rows[k].final_flag = (res_n == srbp_pkg::RES_CNT_W'(k + 1));
        end
    end

    assign o_bundle.n    = res_n;
    assign o_bundle.rows = rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= srbp_pkg::PH_COUNT;
            r_expected <= 8'd0;
            r_done     <= 8'd0;
            r_left     <= 8'd0;
            r_pos      <= 8'd0;
            r_id       <= 32'd0;
            r_hops     <= 8'd0;
            r_dest     <= 3'd0;
            r_err      <= srbp_pkg::VERD_OK;
        end else begin
            r_phase    <= n_phase;
            r_expected <= n_expected;
            r_done     <= n_done;
            r_left     <= n_left;
            r_pos      <= n_pos;
            r_id       <= n_id;
            r_hops     <= n_hops;
            r_dest     <= n_dest;
            r_err      <= n_err;
        end
    end

    // Once an error is latched, only the closing byte may produce a result.
    a_quiet_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && r_err != srbp_pkg::VERD_OK && !i_in.body_end) |-> (o_bundle.n == '0))
        else $error("result produced after a latched error");

    // The closing byte always returns the parser to the start of a batch.
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_in.body_end) |=> (r_phase == srbp_pkg::PH_COUNT
                                       && r_err == srbp_pkg::VERD_OK && r_done == 8'd0))
        else $error("state not cleared after the closing byte");

endmodule

// ===== rtl/srbp_rqueue.sv =====
// Result queue of the sync record batch parser: takes a bundle of up to
// three results per cycle and hands them out one per transfer. Depends on srbp_pkg.
module srbp_rqueue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srbp_pkg::t_bundle i_bundle,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output srbp_pkg::t_res    o_out
);

    srbp_pkg::t_res r_mem [srbp_pkg::Q_DEPTH];
    logic [srbp_pkg::Q_PTR_W-1:0] r_wr, n_wr;
    logic [srbp_pkg::Q_PTR_W-1:0] r_rd, n_rd;
    logic [srbp_pkg::Q_CNT_W-1:0] r_cnt, n_cnt;

    logic                         pop;
    logic [srbp_pkg::Q_PTR_W-1:0] slot_off [srbp_pkg::Q_DEPTH];
    srbp_pkg::t_res               slot_row [srbp_pkg::Q_DEPTH];

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;
    // Room for a full bundle must exist before another byte is taken.
    assign o_full  = (r_cnt > srbp_pkg::Q_CNT_W'(srbp_pkg::Q_DEPTH - srbp_pkg::MAX_RES));
    assign o_out   = r_mem[r_rd];

    always_comb begin
        for (int e = 0; e < srbp_pkg::Q_DEPTH; e++) begin
            slot_off[e] = srbp_pkg::Q_PTR_W'(e) - r_wr;
            case (slot_off[e])
                2'd0:    slot_row[e] = i_bundle.rows[0];
                2'd1:    slot_row[e] = i_bundle.rows[1];
                default: slot_row[e] = i_bundle.rows[2];
            endcase
        end
        n_wr  = r_wr + srbp_pkg::Q_PTR_W'(i_bundle.n);
        n_rd  = r_rd + srbp_pkg::Q_PTR_W'(pop);
        n_cnt = r_cnt + srbp_pkg::Q_CNT_W'(i_bundle.n) - srbp_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < srbp_pkg::Q_DEPTH; e++) begin
            if (srbp_pkg::RES_CNT_W'(slot_off[e]) < i_bundle.n) begin
                r_mem[e] <= slot_row[e];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= srbp_pkg::Q_CNT_W'(srbp_pkg::Q_DEPTH))
        else $error("result queue overflow");

    a_push_only_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_bundle.n != '0) |-> !o_full)
        else $error("bundle pushed while queue lacked room");

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && r_rd == $past(r_rd)))
        else $error("stalled result left the queue");

endmodule

// ===== rtl/sync_record_batch_parser.sv =====
// Top level of the sync record batch parser: channel handshakes, the
// record limit register and the parser and result queue. Depends on srbp_pkg.
//
//   channel   direction  handshake            payload
//   -------   ---------  -------------------  ----------------------------
//   input     in         i_valid / o_stall    i_in  (in_byte, body_end)
//   output    out        o_valid / i_stall    o_out (one result per transfer)
//   config    in         psel/penable/pready  record limit at paddr 0
//
// A byte is decoded in the cycle it is accepted and its results are written
// into the output queue, so the first result is visible in the cycle after.
// One byte per cycle is sustained while each byte causes at most one result
// and the output is not stalled; a byte with two or three results holds later
// bytes back until the single output port drains the four-entry result queue.
// Reset is synchronous and active low and needs no clearing pass.
// o_stall comes only from the queue fill level, never from i_stall directly.
module sync_record_batch_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  srbp_pkg::t_in                     i_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output srbp_pkg::t_res                    o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [srbp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [7:0]        r_rec_limit;
    logic              cfg_wr;
    logic              take;
    logic              q_full;
    srbp_pkg::t_bundle bundle;

    // The register port never inserts wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == srbp_pkg::ADDR_MAX_REC);
    assign prdata = (paddr == srbp_pkg::ADDR_MAX_REC) ? {24'd0, r_rec_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_limit <= srbp_pkg::MAX_REC_RESET;
        end else if (cfg_wr) begin
            r_rec_limit <= pwdata[7:0];
        end
    end

    // A byte transfer completes whenever the queue can absorb a full bundle.
    assign o_stall = q_full;
    assign take    = i_valid && !q_full;

    srbp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_in        (i_in),
        .i_rec_limit (r_rec_limit),
        .o_bundle    (bundle)
    );

    // The queue serializes each bundle so results leave in byte order.
    srbp_rqueue u_rqueue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bundle (bundle),
        .o_full   (q_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_out    (o_out)
    );

endmodule

// ===== sim/tb_sync_record_batch_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sync_record_batch_parser: random batch bodies are
// parsed by a local model and every result transfer is compared with it.
// Depends on srbp_pkg and the sync_record_batch_parser RTL; needs no other file.
module tb_sync_record_batch_parser;
    import srbp_pkg::*;

    // Timing of the run. The block answers in the cycle after a byte is taken,
    // so a short settle covers anything still inside it.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int STUCK_LIMIT   = 2000;
    localparam int QUIET_FROM    = 200;
    localparam int QUIET_TO      = 500;

    // The destination text that marks a broadcast record.
    localparam logic [23:0] BCAST_NAME = "ALL";

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_in                   i_in = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_res                  o_out;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Bytes waiting to be offered, and the results they are known to cause.
    t_in  byte_feed[$];
    t_res due_results[$];
    int   bytes_queued = 0;
    int   bytes_taken = 0;
    int   results_seen = 0;
    int   failures = 0;
    int   cyc = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   stuck_cycles = 0;

    // Scratch space for building one batch body before it is queued.
    t_in  batch_buf[$];
    int   len_at[$];

    // Local copy of the parser state and of the record limit register.
    logic [7:0]  limit_recs = MAX_REC_RESET;
    t_phase      ph = PH_COUNT;
    logic [7:0]  want_recs = '0;
    logic [7:0]  done_recs = '0;
    logic [7:0]  left = '0;
    logic [7:0]  pos = '0;
    logic [31:0] id_acc = '0;
    logic [7:0]  hops = '0;
    logic [2:0]  dmatch = '0;
    logic [2:0]  fault = VERD_OK;

    sync_record_batch_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // Both sides idle about one cycle in five, except in a fixed window early
    // in the run where traffic flows back to back.
    function automatic bit skip_cycle();
        if (cyc >= QUIET_FROM && cyc < QUIET_TO) begin
            return 1'b0;
        end
        return $urandom_range(99) < 21;
    endfunction

    //------------------------------------------------------------------
    // Parser model
    //------------------------------------------------------------------

    function automatic t_res blank_row(input logic [1:0] k);
        t_res r;
        r      = '0;
        r.kind = k;
        return r;
    endfunction

    function automatic void clear_batch();
        ph        = PH_COUNT;
        want_recs = '0;
        done_recs = '0;
        left      = '0;
        pos       = '0;
        id_acc    = '0;
        hops      = '0;
        dmatch    = '0;
        fault     = VERD_OK;
    endfunction

    function automatic void open_record();
        ph     = PH_ID;
        pos    = '0;
        id_acc = '0;
        hops   = '0;
        dmatch = '0;
    endfunction

    // Builds the record-finished result and moves on to the next record, or to
    // the tail once the counted records are all in.
    function automatic t_res close_record();
        t_res r;
        r              = blank_row(KIND_RECORD);
        r.record_index = done_recs;
        r.record_id    = id_acc;
        r.hop_count    = hops;
        r.is_broadcast = (dmatch == DEST_ALL);
        done_recs      = done_recs + 8'd1;
        if (done_recs == want_recs) begin
            ph = PH_TAIL;
        end else begin
            open_record();
        end
        return r;
    endfunction

    // Works out the results of one accepted byte and queues them in order.
    task automatic parse_byte(input t_in it);
        t_res       rows[$];
        t_res       r;
        logic [7:0] b;
        logic [2:0] v;
        b = it.in_byte;
        // Once a fault is latched every byte is ignored until the body ends.
        if (fault == VERD_OK) begin
            case (ph)
                PH_COUNT: begin
                    want_recs = b;
                    done_recs = '0;
                    if (b == 8'd0) begin
                        fault = VERD_EMPTY;
                    end else if (b > limit_recs) begin
                        fault = VERD_MANY;
                    end else begin
                        open_record();
                    end
                end
                PH_ID: begin
                    id_acc = id_acc | (32'(b) << (8 * pos[1:0]));
                    pos    = pos + 8'd1;
                    if (pos >= 8'd4) begin
                        ph = PH_LEN_SRC;
                    end
                end
                PH_LEN_SRC, PH_LEN_DST, PH_LEN_TYP, PH_LEN_PRI: begin
                    if (b == 8'd0 || 32'(b) >= TEXT_FIELD_CAP) begin
                        fault = VERD_BADLEN;
                    end else begin
                        left = b;
                        pos  = '0;
                        ph   = t_phase'(ph + 1);
                    end
                end
                PH_SRC, PH_DST, PH_TYP, PH_PRI: begin
                    r              = blank_row(KIND_DATA);
                    r.record_index = done_recs;
                    r.field_sel    = 3'((ph - PH_LEN_SRC) >> 1);
                    r.byte_pos     = pos;
                    r.data_byte    = b;
                    rows.push_back(r);
                    // The destination counts as broadcast only while every byte
                    // so far has matched the name in order; any miss sticks.
                    if (ph == PH_DST) begin
                        if (pos < 8'd3 && dmatch == pos
                                && b == BCAST_NAME[8 * (2 - pos[1:0]) +: 8]) begin
                            dmatch = 3'(pos + 8'd1);
                        end else begin
                            dmatch = DEST_MISS;
                        end
                    end
                    pos  = pos + 8'd1;
                    left = left - 8'd1;
                    if (left == 8'd0) begin
                        ph = t_phase'(ph + 1);
                    end
                end
                PH_HOPS: begin
                    hops = b;
                    ph   = PH_PLEN;
                end
                PH_PLEN: begin
                    if (32'(b) >= PAYLOAD_CAP) begin
                        fault = VERD_BADLEN;
                    end else if (b == 8'd0) begin
                        rows.push_back(close_record());
                    end else begin
                        left = b;
                        pos  = '0;
                        ph   = PH_PAY;
                    end
                end
                PH_PAY: begin
                    r              = blank_row(KIND_DATA);
                    r.record_index = done_recs;
                    r.field_sel    = FSEL_PAY;
                    r.byte_pos     = pos;
                    r.data_byte    = b;
                    rows.push_back(r);
                    pos  = pos + 8'd1;
                    left = left - 8'd1;
                    if (left == 8'd0) begin
                        rows.push_back(close_record());
                    end
                end
                default: begin
                    // Anything after the last counted record.
                    fault = VERD_TRAIL;
                end
            endcase
        end
        if (it.body_end) begin
            if (fault != VERD_OK) begin
                v = fault;
            end else if (ph == PH_TAIL) begin
                v = VERD_OK;
            end else begin
                v = VERD_TRUNC;
            end
            r               = blank_row(KIND_VERDICT);
            r.verdict       = v;
            r.records_total = (v == VERD_OK) ? done_recs : 8'd0;
            rows.push_back(r);
            clear_batch();
        end
        if (rows.size() != 0) begin
            rows[rows.size() - 1].final_flag = 1'b1;
        end
        foreach (rows[k]) begin
            due_results.push_back(rows[k]);
        end
    endtask

    //------------------------------------------------------------------
    // Input driver: offers queued bytes, holding each one steady until its
    // transfer, and hands every accepted byte to the model.
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_byte(i_in);
                bytes_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (byte_feed.size() != 0 && !skip_cycle()) begin
                    i_valid <= 1'b1;
                    i_in    <= byte_feed.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Output monitor: checks each result transfer against the oldest
    // expectation and drives the receiver stall.
    //------------------------------------------------------------------
    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    $error("result transfer of kind %0d with nothing expected", o_out.kind);
                    failures++;
                end else begin
                    e = due_results.pop_front();
                    check_field("kind", e.kind, o_out.kind);
                    check_field("record_index", e.record_index, o_out.record_index);
                    check_field("field_sel", e.field_sel, o_out.field_sel);
                    check_field("byte_pos", e.byte_pos, o_out.byte_pos);
                    check_field("data_byte", e.data_byte, o_out.data_byte);
                    check_field("record_id", e.record_id, o_out.record_id);
                    check_field("hop_count", e.hop_count, o_out.hop_count);
                    check_field("is_broadcast", e.is_broadcast, o_out.is_broadcast);
                    check_field("verdict", e.verdict, o_out.verdict);
                    check_field("records_total", e.records_total, o_out.records_total);
                    check_field("final_flag", e.final_flag, o_out.final_flag);
                end
            end
            // One long hold-off while plenty of bytes are still queued, so the
            // result queue fills and the block has to stall its input.
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && results_seen >= 40 && byte_feed.size() > 16) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= skip_cycle();
            end
        end
    end

    // Ends the run when no transfer happens on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------

    task automatic feed(input logic [7:0] b, input bit last);
        t_in x;
        x.in_byte  = b;
        x.body_end = last;
        byte_feed.push_back(x);
        bytes_queued++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        t_in x;
        x.in_byte  = b;
        x.body_end = 1'b0;
        batch_buf.push_back(x);
    endtask

    // One length-prefixed text field. The destination is often the broadcast
    // name or a near miss of it.
    task automatic put_field(input int f, input bit big);
        int n;
        int m;
        m = (f == 1) ? $urandom_range(5) : 5;
        len_at.push_back(batch_buf.size());
        case (m)
            0, 1: begin
                put_byte(8'd3); put_byte("A"); put_byte("L"); put_byte("L");
            end
            2: begin
                put_byte(8'd2); put_byte("A"); put_byte("L");
            end
            3: begin
                put_byte(8'd4); put_byte("A"); put_byte("L"); put_byte("L");
                put_byte(8'($urandom_range(255)));
            end
            4: begin
                put_byte(8'd3); put_byte("A"); put_byte("L");
                put_byte(8'($urandom_range(255)));
            end
            default: begin
                if (big) begin
                    n = TEXT_FIELD_CAP - 1;
                end else if ($urandom_range(7) == 0) begin
                    n = $urandom_range(1, TEXT_FIELD_CAP - 1);
                end else begin
                    n = $urandom_range(1, 4);
                end
                put_byte(8'(n));
                repeat (n) put_byte(8'($urandom_range(255)));
            end
        endcase
    endtask

    task automatic put_record(input bit big);
        int n;
        repeat (4) put_byte(8'($urandom_range(255)));
        for (int f = 0; f < 4; f++) begin
            put_field(f, big);
        end
        put_byte(8'($urandom_range(255)));
        if ($urandom_range(19) == 0) begin
            n = $urandom_range(0, PAYLOAD_CAP - 1);
        end else begin
            n = $urandom_range(0, 6);
        end
        put_byte(8'(n));
        repeat (n) put_byte(8'($urandom_range(255)));
    endtask

    // Builds one batch body: mostly well formed, otherwise with one fault
    // injected, or plain noise. A big batch carries the longest fields.
    task automatic add_batch(input bit big, output int used);
        int nrec;
        int top;
        int pick;
        int keep;
        batch_buf.delete();
        len_at.delete();
        top  = (limit_recs < 8'd3) ? int'(limit_recs) : 3;
        nrec = big ? 1 : $urandom_range(1, top);
        put_byte(8'(nrec));
        repeat (nrec) put_record(big);
        pick = big ? 0 : $urandom_range(99);
        if (pick < 55) begin
            // Well formed.
        end else if (pick < 63) begin
            // Count promises more records than the body holds.
            batch_buf[0].in_byte = 8'(nrec + $urandom_range(1, 2));
        end else if (pick < 71) begin
            keep = $urandom_range(1, batch_buf.size() - 1);
            while (batch_buf.size() > keep) void'(batch_buf.pop_back());
        end else if (pick < 79) begin
            keep = len_at[$urandom_range(0, len_at.size() - 1)];
            batch_buf[keep].in_byte = $urandom_range(1) ? 8'd0
                                      : 8'($urandom_range(TEXT_FIELD_CAP, 255));
        end else if (pick < 86) begin
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(255)));
        end else if (pick < 91) begin
            batch_buf[0].in_byte = (limit_recs == 8'd255) ? 8'd0
                                   : 8'($urandom_range(limit_recs + 1, 255));
        end else if (pick < 95) begin
            batch_buf[0].in_byte = 8'd0;
        end else begin
            batch_buf.delete();
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(255)));
        end
        batch_buf[batch_buf.size() - 1].body_end = 1'b1;
        foreach (batch_buf[k]) begin
            feed(batch_buf[k].in_byte, batch_buf[k].body_end);
        end
        used = batch_buf.size();
    endtask

    task automatic run_random(input int budget);
        int spent;
        int used;
        spent = 0;
        while (spent < budget) begin
            add_batch(1'b0, used);
            spent += used;
        end
    endtask

    // Waits until every queued byte has been taken and every expected result
    // has arrived, then lets the block settle.
    task automatic drain();
        while (bytes_taken != bytes_queued || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic set_limit(input logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_REC;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        limit_recs = value;
    endtask

    initial begin
        int used;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_limit(8'd255);
        // Empty batch.
        feed(8'd0, 1'b1);
        // One well-formed broadcast record with a one-byte payload.
        feed(8'd1, 1'b0);
        feed(8'h78, 1'b0); feed(8'h56, 1'b0); feed(8'h34, 1'b0); feed(8'h12, 1'b0);
        feed(8'd1, 1'b0); feed(8'h00, 1'b0);
        feed(8'd3, 1'b0); feed("A", 1'b0); feed("L", 1'b0); feed("L", 1'b0);
        feed(8'd1, 1'b0); feed(8'hFF, 1'b0);
        feed(8'd1, 1'b0); feed(8'h7F, 1'b0);
        feed(8'hFF, 1'b0);
        feed(8'd1, 1'b0); feed(8'h80, 1'b1);
        // Source length at the cap, ending on the faulty byte.
        feed(8'd1, 1'b0);
        feed(8'hFF, 1'b0); feed(8'hFF, 1'b0); feed(8'hFF, 1'b0); feed(8'hFF, 1'b0);
        feed(8'(TEXT_FIELD_CAP), 1'b1);
        // Body that ends right after the count.
        feed(8'd1, 1'b1);
        drain();

        set_limit(8'd1);
        // Two records against a limit of one.
        feed(8'd2, 1'b1);
        run_random(40);
        drain();

        set_limit(8'($urandom_range(2, 6)));
        run_random(50);
        drain();

        set_limit(8'd255);
        add_batch(1'b1, used);
        run_random(40);
        drain();

        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
